/* src/multichannel_newton_interpolator_unit_defines.svh */
// Assertion helpers for the RTL, used in nmi_back. Each use sits on a line of its own.
`ifndef MULTICHANNEL_NEWTON_INTERPOLATOR_UNIT_DEFINES_SVH
`define MULTICHANNEL_NEWTON_INTERPOLATOR_UNIT_DEFINES_SVH

// Property checked on every rising clock edge, off while reset is held
`define NMI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true on a rising clock edge, off while reset is held
`define NMI_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* src/nmi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package nmi_pkg;

  localparam int unsigned MemWordsDefault = 4096;
  localparam int unsigned FracBits        = 16;
  localparam int unsigned AddrBits        = 12;
  localparam int unsigned SampleBits      = 16;
  localparam int unsigned StrideBits      = 5;
  // widest word index over the supported memory sizes
  localparam int unsigned MaxIdxBits      = 16;
  localparam int unsigned QueueDepth      = 2;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_INTERP = 1'b1
  } opcode_e;

  typedef enum logic [0:0] {
    CFG_ORDER  = 1'b0,
    CFG_STRIDE = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ORDER_NONE   = 2'd0,
    ORDER_LINEAR = 2'd1,
    ORDER_QUAD   = 2'd2,
    ORDER_CUBIC  = 2'd3
  } order_e;

  // One classified item between front and back
  typedef struct packed {
    opcode_e                op;
    logic                   oor;     // load: drop the write; interpolate: neighbour outside
    order_e                 order;   // effective order, linear to cubic
    logic [MaxIdxBits-1:0]  base;    // first word to touch
    logic [StrideBits-1:0]  stride;
    logic [SampleBits-1:0]  sample;
    logic [FracBits-1:0]    frac;
  } job_t;

  // Gathered item handed to the arithmetic pipeline
  typedef struct packed {
    logic                 valid;
    logic                 oor;
    order_e               order;
    logic [FracBits-1:0]  frac;
  } math_in_t;

endpackage
`default_nettype wire

/* src/nmi_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module nmi_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* src/nmi_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module nmi_front import nmi_pkg::*; #(
  parameter int unsigned MEM_WORDS = MemWordsDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [0:0]            cfg_index_i,
  input  wire logic [StrideBits-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  in_op_i,
  input  wire logic [AddrBits-1:0]   in_addr_i,
  input  wire logic [SampleBits-1:0] in_sample_i,
  input  wire logic [FracBits-1:0]   in_frac_i,
  input  wire logic                  full_i,
  output logic                       push_o,
  output job_t                       job_o
);

  localparam int unsigned MW = $clog2(MEM_WORDS);
  localparam int unsigned IW = ((MW > AddrBits) ? MW : AddrBits) + 2;
  localparam logic signed [IW-1:0] Limit = IW'(MEM_WORDS);

  order_e                order_q;
  logic [StrideBits-1:0] stride_q;
  order_e                eff_order;
  opcode_e               op;
  logic                  cubic;
  logic signed [IW-1:0]  addr_s, stride_s, base_s, span_s, top_s;
  logic                  interp_oor, load_oor;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q  <= ORDER_CUBIC;
      stride_q <= StrideBits'(1);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_ORDER:  order_q  <= order_e'(cfg_data_i[1:0]);
        CFG_STRIDE: stride_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // classify the beat and check the neighbour window against the memory
  always_comb begin
    op        = opcode_e'(in_op_i);
    eff_order = (order_q == ORDER_NONE) ? ORDER_LINEAR : order_q;
    cubic     = (op == OP_INTERP) && (eff_order == ORDER_CUBIC);
    addr_s    = $signed({{(IW-AddrBits){1'b0}}, in_addr_i});
    stride_s  = $signed({{(IW-StrideBits){1'b0}}, stride_q});
    base_s    = cubic ? (addr_s - stride_s) : addr_s;
    case (eff_order)
      ORDER_QUAD:  span_s = stride_s <<< 1;
      ORDER_CUBIC: span_s = (stride_s <<< 1) + stride_s;
      default:     span_s = stride_s;
    endcase
    top_s      = base_s + span_s;
    interp_oor = (base_s < 0) || (top_s >= Limit);
    load_oor   = (addr_s >= Limit);

    job_o.op     = op;
    job_o.oor    = (op == OP_LOAD) ? load_oor : interp_oor;
    job_o.order  = eff_order;
    job_o.base   = MaxIdxBits'($unsigned(base_s));
    job_o.stride = stride_q;
    job_o.sample = in_sample_i;
    job_o.frac   = in_frac_i;
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule
`default_nettype wire

/* src/nmi_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module nmi_queue import nmi_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output job_t      head_o
);

  localparam int unsigned PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  job_t               slot_q [QueueDepth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [CntBits-1:0] cnt_q;

  function automatic logic [PtrBits-1:0] nxt(input logic [PtrBits-1:0] p);
    return (p == PtrBits'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  // store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= nxt(wr_q);
      if (pop_i)  rd_q <= nxt(rd_q);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign full_o  = (cnt_q == CntBits'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_q];

endmodule
`default_nettype wire

/* src/nmi_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "multichannel_newton_interpolator_unit_defines.svh"
module nmi_back import nmi_pkg::*; #(
  parameter int unsigned MEM_WORDS = MemWordsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic                          q_valid_i,
  input  job_t                               q_head_i,
  output logic                               q_pop_o,
  output logic                               ram_we_o,
  output logic                               ram_re_o,
  output logic [$clog2(MEM_WORDS)-1:0]       ram_addr_o,
  output logic [SampleBits-1:0]              ram_wdata_o,
  input  wire logic [SampleBits-1:0]         ram_rdata_i,
  output math_in_t                           math_o,
  output logic [3:0][SampleBits-1:0]         b_o
);

  localparam int unsigned MW = $clog2(MEM_WORDS);

  // read sequencer
  job_t          cur_q, cur_d;
  logic          busy_q, busy_d;
  logic [1:0]    k_q, k_d;
  logic [MW-1:0] raddr_q, raddr_d;

  // read in flight
  logic          pend_valid_q, pend_valid_d;
  logic          pend_last_q, pend_last_d;
  logic          pend_oor_q, pend_oor_d;
  logic [1:0]    pend_k_q, pend_k_d;
  order_e        pend_order_q, pend_order_d;
  logic [FracBits-1:0] pend_frac_q, pend_frac_d;

  // gathered neighbours
  logic [3:0][SampleBits-1:0] b_q;
  logic                g_valid_q;
  logic                g_oor_q;
  order_e              g_order_q;
  logic [FracBits-1:0] g_frac_q;

  function automatic logic [MW-1:0] stride_w(input logic [StrideBits-1:0] s);
    return {{(MW-StrideBits){1'b0}}, s};
  endfunction

  // issue at most one memory access per cycle while adv_i is high: a write, or the next neighbour read
  always_comb begin
    cur_d        = cur_q;
    busy_d       = busy_q;
    k_d          = k_q;
    raddr_d      = raddr_q;
    q_pop_o      = 1'b0;
    ram_we_o     = 1'b0;
    ram_re_o     = 1'b0;
    ram_addr_o   = raddr_q;
    ram_wdata_o  = q_head_i.sample;
    pend_valid_d = 1'b0;
    pend_last_d  = pend_last_q;
    pend_oor_d   = pend_oor_q;
    pend_k_d     = pend_k_q;
    pend_order_d = pend_order_q;
    pend_frac_d  = pend_frac_q;
    if (adv_i) begin
      if (busy_q) begin
        ram_re_o     = 1'b1;
        raddr_d      = raddr_q + stride_w(cur_q.stride);
        k_d          = k_q + 1'b1;
        pend_valid_d = 1'b1;
        pend_k_d     = k_q;
        pend_last_d  = (k_q == cur_q.order);
        pend_oor_d   = 1'b0;
        pend_order_d = cur_q.order;
        pend_frac_d  = cur_q.frac;
        if (k_q == cur_q.order) begin
          busy_d = 1'b0;
        end
      end else if (q_valid_i) begin
        q_pop_o    = 1'b1;
        ram_addr_o = q_head_i.base[MW-1:0];
        case (q_head_i.op)
          OP_LOAD: begin
            ram_we_o = !q_head_i.oor;
          end
          OP_INTERP: begin
            pend_valid_d = 1'b1;
            pend_k_d     = 2'd0;
            pend_order_d = q_head_i.order;
            pend_frac_d  = q_head_i.frac;
            if (q_head_i.oor) begin
              // nothing to read: send the flag on its own
              pend_last_d = 1'b1;
              pend_oor_d  = 1'b1;
            end else begin
              ram_re_o    = 1'b1;
              pend_last_d = 1'b0;
              pend_oor_d  = 1'b0;
              raddr_d     = q_head_i.base[MW-1:0] + stride_w(q_head_i.stride);
              cur_d       = q_head_i;
              k_d         = 2'd1;
              busy_d      = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // sequencer and in-flight state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      g_valid_q    <= 1'b0;
    end else if (adv_i) begin
      busy_q       <= busy_d;
      pend_valid_q <= pend_valid_d;
      g_valid_q    <= pend_valid_q && pend_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    k_q          <= k_d;
    raddr_q      <= raddr_d;
    pend_last_q  <= pend_last_d;
    pend_oor_q   <= pend_oor_d;
    pend_k_q     <= pend_k_d;
    pend_order_q <= pend_order_d;
    pend_frac_q  <= pend_frac_d;
  end

  // collect returning words; launch on the last one
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (pend_valid_q && !pend_oor_q) begin
        b_q[pend_k_q] <= ram_rdata_i;
      end
      g_oor_q   <= pend_oor_q;
      g_order_q <= pend_order_q;
      g_frac_q  <= pend_frac_q;
    end
  end

  assign math_o.valid = g_valid_q;
  assign math_o.oor   = g_oor_q;
  assign math_o.order = g_order_q;
  assign math_o.frac  = g_frac_q;
  assign b_o          = b_q;

  `NMI_ASSERT(read_count_bounded, busy_q |-> (k_q <= cur_q.order), "read counter past order")
  `NMI_ASSERT_NEVER(single_port_use, ram_we_o && ram_re_o, "write and read in one cycle")
  `NMI_ASSERT_NEVER(pop_while_reading, q_pop_o && busy_q, "queue popped mid item")
  `NMI_ASSERT(last_word_launched, (adv_i && pend_valid_q && pend_last_q) |=> g_valid_q, "last word not launched")

endmodule
`default_nettype wire

/* src/nmi_math.sv */
`timescale 1ns / 1ps
`default_nettype none
module nmi_math import nmi_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  math_in_t                          in_i,
  input  wire logic [3:0][SampleBits-1:0]   b_i,
  output logic                              adv_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [SampleBits-1:0]             out_value_o,
  output logic                              out_oor_o,
  output logic                              out_sat_o
);

  localparam logic signed [17:0] OneS   = 18'sd65536;
  localparam logic signed [18:0] TwoS   = 19'sd131072;
  localparam logic signed [35:0] HalfW2 = 36'sd65536;
  localparam logic signed [39:0] ThreeS = 40'sd196608;
  localparam logic signed [23:0] Off3   = 24'sd786432;   // 3 * 2^18
  localparam logic [20:0]        Recip3 = 21'd1398101;   // floor(2^22 / 3)
  localparam logic signed [19:0] W3Bias = 20'sd262144;   // 2^18
  localparam logic signed [43:0] HalfLsb = 44'sd32768;

  logic [5:0] vld_q;
  logic [5:0] oor_q;

  // stage 1
  logic signed [15:0] b0, b1, b2, b3;
  logic signed [17:0] tee, tms;
  logic signed [19:0] d1, d2, d3;
  logic signed [17:0] s1_tee_q;
  logic signed [35:0] s1_p1_q;
  logic signed [15:0] s1_b0_q;
  logic signed [19:0] s1_d1_q, s1_d2_q, s1_d3_q;
  // stage 2
  logic signed [18:0] s2_w2_q;
  logic signed [17:0] s2_tee_q;
  logic signed [37:0] s2_m1_q;
  logic signed [15:0] s2_b0_q;
  logic signed [19:0] s2_d2_q, s2_d3_q;
  // stage 3
  logic signed [18:0] tm2;
  logic signed [37:0] prod2;
  logic signed [39:0] s3_p2_q;
  logic signed [38:0] s3_m2_q;
  logic signed [43:0] s3_a_q;
  logic signed [19:0] s3_d3_q;
  // stage 4
  logic signed [23:0] u24;
  logic [40:0]        q0;
  logic [19:0]        s4_u_q;
  logic [18:0]        s4_qh_q;
  logic signed [43:0] s4_a_q;
  logic signed [19:0] s4_d3_q;
  // stage 5
  logic [20:0]        t3, rem;
  logic [18:0]        qf;
  logic signed [19:0] s5_w3_q;
  logic signed [43:0] s5_a_q;
  logic signed [19:0] s5_d3_q;
  // stage 6
  logic signed [39:0] s6_m3_q;
  logic signed [43:0] s6_a_q;
  // output
  logic signed [43:0] acc;
  logic signed [27:0] res;
  logic               out_valid_q;
  logic [SampleBits-1:0] out_value_q;
  logic               out_oor_q, out_sat_q;
  logic [SampleBits-1:0] value_d;
  logic               sat_d;

  assign adv_o = !out_valid_q || out_ready_i;

  // differences and position
  always_comb begin
    b0  = $signed(b_i[0]);
    b1  = $signed(b_i[1]);
    b2  = $signed(b_i[2]);
    b3  = $signed(b_i[3]);
    tee = $signed({1'b0, (in_i.order == ORDER_CUBIC), in_i.frac});
    tms = tee - OneS;
    d1  = 20'(b1) - 20'(b0);
    d2  = (in_i.order == ORDER_LINEAR) ? 20'sd0 :
          20'(b2) - (20'(b1) <<< 1) + 20'(b0);
    d3  = (in_i.order != ORDER_CUBIC) ? 20'sd0 :
          20'(b3) - 20'sd3 * 20'(b2) + 20'sd3 * 20'(b1) - 20'(b0);
  end

  // cubic weight: floor of a signed value by three, biased positive
  always_comb begin
    tm2   = $signed({s2_tee_q[17], s2_tee_q}) - TwoS;
    prod2 = s2_w2_q * tm2;
    u24   = $signed({s3_p2_q[39], s3_p2_q[39:17]}) + Off3;
    q0    = u24[19:0] * Recip3;
    t3    = {1'b0, s4_qh_q, 1'b0} + {2'b00, s4_qh_q};
    rem   = {1'b0, s4_u_q} - t3;
    qf    = (rem >= 21'd3) ? s4_qh_q + 1'b1 : s4_qh_q;
  end

  // final sum, round and clip; zero for an out-of-range item
  always_comb begin
    acc     = s6_a_q + 44'(s6_m3_q);
    res     = 28'((acc + HalfLsb) >>> 16);
    sat_d   = 1'b0;
    value_d = res[SampleBits-1:0];
    if (res > 28'sd32767) begin
      value_d = 16'h7FFF;
      sat_d   = 1'b1;
    end else if (res < -28'sd32768) begin
      value_d = 16'h8000;
      sat_d   = 1'b1;
    end
    if (oor_q[5]) begin
      value_d = '0;
      sat_d   = 1'b0;
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      vld_q       <= {vld_q[4:0], in_i.valid};
      out_valid_q <= vld_q[5];
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      oor_q    <= {oor_q[4:0], in_i.oor};
      s1_tee_q <= tee;
      s1_p1_q  <= tee * tms;
      s1_b0_q  <= b0;
      s1_d1_q  <= d1;
      s1_d2_q  <= d2;
      s1_d3_q  <= d3;

      s2_w2_q  <= 19'((s1_p1_q + HalfW2) >>> 17);
      s2_tee_q <= s1_tee_q;
      s2_m1_q  <= s1_d1_q * s1_tee_q;
      s2_b0_q  <= s1_b0_q;
      s2_d2_q  <= s1_d2_q;
      s2_d3_q  <= s1_d3_q;

      s3_p2_q  <= $signed({prod2[37], prod2, 1'b0}) + ThreeS;
      s3_m2_q  <= s2_d2_q * s2_w2_q;
      s3_a_q   <= $signed({{12{s2_b0_q[15]}}, s2_b0_q, 16'h0000}) + 44'(s2_m1_q);
      s3_d3_q  <= s2_d3_q;

      s4_u_q   <= u24[19:0];
      s4_qh_q  <= q0[40:22];
      s4_a_q   <= s3_a_q + 44'(s3_m2_q);
      s4_d3_q  <= s3_d3_q;

      s5_w3_q  <= $signed({1'b0, qf}) - W3Bias;
      s5_a_q   <= s4_a_q;
      s5_d3_q  <= s4_d3_q;

      s6_m3_q  <= s5_d3_q * s5_w3_q;
      s6_a_q   <= s5_a_q;

      out_value_q <= value_d;
      out_oor_q   <= oor_q[5];
      out_sat_q   <= sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_oor_o   = out_oor_q;
  assign out_sat_o   = out_sat_q;

endmodule
`default_nettype wire

/* src/multichannel_newton_interpolator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Newton-Gregory playback interpolator over an interleaved sample memory of MEM_WORDS
// 16-bit words (contents undefined until loaded; no clearing pass after reset). A load
// beat takes the single memory port for one write; an interpolate beat issues order+1
// neighbour reads (linear two, quadratic three, cubic four) on that port and an
// out-of-range one issues none, so a steady stream is bounded by the neighbour reads on
// that one port. Results leave in input order. A two-entry queue sits between the input
// classifier and the read sequencer; while a result waits at the output the back end and
// arithmetic pipeline stall, and the queue takes beats until full. Write the order and
// stride registers only while no beat is in flight.
module multichannel_newton_interpolator_unit import nmi_pkg::*; #(
  parameter int unsigned MEM_WORDS = MemWordsDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration writes: index 0 interp_order, 1 channel_stride
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [0:0]            cfg_index_i,
  input  wire logic [StrideBits-1:0] cfg_data_i,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [47:0]           s_axis_tdata,  // address[11:0], sample_value[27:12],
                                                    // fraction[43:28], zero pad
  input  wire logic [0:0]            s_axis_tuser,  // opcode
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [15:0]                m_axis_tdata,  // interpolated[15:0]
  output logic [1:0]                 m_axis_tuser   // out_of_range[0], saturated[1]
);

  localparam int unsigned MW = $clog2(MEM_WORDS);

  job_t                       push_job, head_job;
  logic                       push, full, q_valid, q_pop;
  logic                       adv;
  logic                       ram_we, ram_re;
  logic [MW-1:0]              ram_addr;
  logic [SampleBits-1:0]      ram_wdata, ram_rdata;
  math_in_t                   math_in;
  logic [3:0][SampleBits-1:0] nb;

  nmi_front #(.MEM_WORDS(MEM_WORDS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser[0]),
    .in_addr_i   (s_axis_tdata[11:0]),
    .in_sample_i (s_axis_tdata[27:12]),
    .in_frac_i   (s_axis_tdata[43:28]),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  nmi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (head_job)
  );

  nmi_back #(.MEM_WORDS(MEM_WORDS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .q_valid_i   (q_valid),
    .q_head_i    (head_job),
    .q_pop_o     (q_pop),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata),
    .math_o      (math_in),
    .b_o         (nb)
  );

  nmi_ram #(.WIDTH(SampleBits), .DEPTH(MEM_WORDS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  nmi_math u_math (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (math_in),
    .b_i         (nb),
    .adv_o       (adv),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (m_axis_tdata),
    .out_oor_o   (m_axis_tuser[0]),
    .out_sat_o   (m_axis_tuser[1])
  );

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb;
  import nmi_pkg::*;

  localparam int unsigned Words = 4096;
  localparam longint Scale = 64'sd65536;

  typedef struct {
    opcode_e     op;
    logic [11:0] addr;
    logic [15:0] sample;
    logic [15:0] frac;
  } beat_t;

  typedef struct {
    logic [15:0] value;
    logic        oor;
    logic        sat;
  } interp_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [0:0] cfg_index_i = '0;
  logic [StrideBits-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic s_axis_tready_q = 1'b0;
  logic m_axis_tvalid_q = 1'b0;

  multichannel_newton_interpolator_unit i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #6 clk_i = ~clk_i;

  // shadow state of the block
  logic [15:0] mem_shadow [Words];
  bit          mem_written [Words];
  logic [1:0]  cur_order = 2'd3;
  logic [4:0]  cur_stride = 5'd1;

  beat_t       pending_beats [$];
  interp_res_t expected_results [$];
  int          errors = 0;
  bit          stim_done = 1'b0;

  function automatic longint fdiv(longint x, longint d);
    longint q;
    q = x / d;
    if ((x % d) != 0 && x < 0) q--;
    return q;
  endfunction

  function automatic longint word_at(int idx);
    return longint'($signed(mem_shadow[idx]));
  endfunction

  // compute the interpolation result for one beat under the current settings
  function automatic interp_res_t interpolate(beat_t b);
    interp_res_t r;
    int ord, k;
    longint base, strd, t, w2, w3, acc, res, idx;
    longint nb [4];
    ord = (cur_order == ORDER_NONE) ? 1 : int'(cur_order);
    strd = longint'(cur_stride);
    base = longint'(b.addr);
    t = longint'(b.frac);
    if (ord == 3) begin
      base -= strd;
      t += Scale;
    end
    r = '{16'd0, 1'b0, 1'b0};
    for (k = 0; k < 4; k++) nb[k] = 0;
    for (k = 0; k <= ord; k++) begin
      idx = base + k * strd;
      if (idx < 0 || idx >= Words) begin
        r.oor = 1'b1;
        return r;
      end
      nb[k] = word_at(int'(idx));
    end
    acc = nb[0] * Scale + (nb[1] - nb[0]) * t;
    if (ord >= 2) begin
      w2 = fdiv(t * (t - Scale) + Scale, 2 * Scale);
      acc += (nb[2] - 2 * nb[1] + nb[0]) * w2;
      if (ord == 3) begin
        w3 = fdiv(2 * w2 * (t - 2 * Scale) + 3 * Scale, 6 * Scale);
        acc += (nb[3] - 3 * nb[2] + 3 * nb[1] - nb[0]) * w3;
      end
    end
    res = fdiv(acc + Scale / 2, Scale);
    if (res > 32767) begin
      res = 32767;
      r.sat = 1'b1;
    end else if (res < -32768) begin
      res = -32768;
      r.sat = 1'b1;
    end
    r.value = res[15:0];
    return r;
  endfunction

  // true when every word the beat touches has been loaded, or when the beat is out of range
  function automatic bit reads_loaded(beat_t b);
    int ord, k;
    longint base, idx;
    ord = (cur_order == ORDER_NONE) ? 1 : int'(cur_order);
    base = longint'(b.addr) - ((ord == 3) ? longint'(cur_stride) : 0);
    for (k = 0; k <= ord; k++) begin
      idx = base + k * longint'(cur_stride);
      if (idx < 0 || idx >= Words) return 1'b1;
    end
    for (k = 0; k <= ord; k++) begin
      idx = base + k * longint'(cur_stride);
      if (!mem_written[idx]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // driver: one beat at a time with a random gap
  int send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready_q) begin
        if (pending_beats.size() > 0) begin
          void'(pending_beats.pop_front());
        end
        send_gap = $urandom_range(0, 7);
      end
      if (s_axis_tvalid && !s_axis_tready_q) begin
        // hold the beat
      end else if (pending_beats.size() > 0 && send_gap == 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_beats[0].op;
        s_axis_tdata <= {4'd0, pending_beats[0].frac, pending_beats[0].sample,
                         pending_beats[0].addr};
      end else begin
        s_axis_tvalid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end
    end
  end

  // sampled acceptance at the rising edge, consumed by the driver
  always @(posedge clk_i) begin
    s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
  end

  // monitor: check each result beat against the oldest expectation
  int sink_gap = 0;
  always @(posedge clk_i) begin
    interp_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat %h/%b", $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (m_axis_tdata !== e.value) begin
          $display("%0t: interpolated expected %h actual %h", $time, e.value, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser[0] !== e.oor) begin
          $display("%0t: out_of_range expected %b actual %b", $time, e.oor, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[1] !== e.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, e.sat, m_axis_tuser[1]);
          errors++;
        end
      end
    end
  end

  // sink stall pattern, drawn per result beat
  always @(negedge clk_i) begin
    if (m_axis_tready && m_axis_tvalid_q) sink_gap = $urandom_range(0, 7);
    if (sink_gap > 0) begin
      m_axis_tready <= 1'b0;
      sink_gap--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end
  always @(posedge clk_i) m_axis_tvalid_q <= m_axis_tvalid && m_axis_tready;

  // predict at acceptance so shadow memory follows the input order
  always @(posedge clk_i) begin
    beat_t b;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      b.op = opcode_e'(s_axis_tuser[0]);
      b.addr = s_axis_tdata[11:0];
      b.sample = s_axis_tdata[27:12];
      b.frac = s_axis_tdata[43:28];
      if (b.op == OP_LOAD) begin
        mem_shadow[b.addr] = b.sample;
        mem_written[b.addr] = 1'b1;
      end else begin
        expected_results.push_back(interpolate(b));
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [4:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_ORDER) cur_order = val[1:0];
    else cur_stride = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // wait until the block has drained
  task automatic drain();
    while (pending_beats.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic beat_t load_beat(int a, logic [15:0] v);
    beat_t b;
    b.op = OP_LOAD;
    b.addr = a[11:0];
    b.sample = v;
    b.frac = 16'($urandom);
    return b;
  endfunction

  function automatic beat_t interp_beat(int a, logic [15:0] f);
    beat_t b;
    b.op = OP_INTERP;
    b.addr = a[11:0];
    b.sample = 16'($urandom);
    b.frac = f;
    return b;
  endfunction

  // pick a word in one of the two loaded regions at the ends of the memory
  function automatic int pick_addr();
    int a;
    a = $urandom_range(0, 511);
    return (a < 256) ? a : a + int'(Words) - 512;
  endfunction

  // queue an interpolation only if it reads loaded words
  task automatic push_interp(beat_t b);
    if (reads_loaded(b)) pending_beats.push_back(b);
  endtask

  initial begin
    int i, n;
    beat_t b;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // fill both ends of the memory so reads there are defined
    for (i = 0; i < Words; i++) begin
      if (i < 256 || i >= int'(Words) - 256) begin
        case (i % 4)
          0: pending_beats.push_back(load_beat(i, 16'h7fff));
          1: pending_beats.push_back(load_beat(i, 16'h8000));
          default: pending_beats.push_back(load_beat(i, 16'($urandom)));
        endcase
        mem_written[i] = 1'b1;
      end
    end
    drain();
    // directed: extremes, saturation and out-of-range at each order
    for (n = 0; n < 4; n++) begin
      write_reg(CFG_ORDER, 5'(n));
      write_reg(CFG_STRIDE, (n == 2) ? 5'd16 : 5'd1);
      push_interp(interp_beat(0, 16'h0000));
      push_interp(interp_beat(0, 16'hffff));
      push_interp(interp_beat(4095, 16'h8000));
      push_interp(interp_beat(1, 16'hffff));
      push_interp(interp_beat(4080, 16'h1234));
      drain();
    end
    write_reg(CFG_STRIDE, 5'd0);
    push_interp(interp_beat(100, 16'haaaa));
    push_interp(interp_beat(4095, 16'h5555));
    drain();
    write_reg(CFG_STRIDE, 5'd31);
    push_interp(interp_beat(4090, 16'h5555));
    drain();
    // random phases with random settings
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_ORDER, 5'($urandom_range(0, 3)));
      write_reg(CFG_STRIDE, (ph == 9) ? 5'd16 : 5'($urandom_range(0, 31)));
      for (i = 0; i < 110; i++) begin
        if ($urandom_range(0, 3) == 0)
          b = load_beat(pick_addr(), 16'($urandom));
        else if ($urandom_range(0, 9) == 0)
          b = interp_beat($urandom_range(0, 40) + (($urandom_range(0, 1)) ? 4055 : 0),
                          16'($urandom));
        else
          b = interp_beat(pick_addr(), 16'($urandom));
        if (b.op == OP_LOAD) pending_beats.push_back(b);
        else push_interp(b);
      end
      drain();
    end
    stim_done = 1'b1;
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

/* multichannel_newton_interpolator_unit.f */
+incdir+src
src/nmi_pkg.sv
src/nmi_ram.sv
src/nmi_front.sv
src/nmi_queue.sv
src/nmi_back.sv
src/nmi_math.sv
src/multichannel_newton_interpolator_unit.sv
verif/tb.sv
